### rtl/pepf_pkg.sv
// Package for the printer escape passthrough filter.
// Byte codes, mode codes and the structs passed between the filter modules.
// No dependencies.
`timescale 1ns / 1ps

package pepf_pkg;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_AT    = 8'h40;
  localparam logic [7:0] BYTE_UC_Z  = 8'h5A;
  localparam logic [7:0] BYTE_UC_Y  = 8'h59;
  localparam logic [7:0] BYTE_UC_W  = 8'h57;
  localparam logic [7:0] BYTE_UC_X  = 8'h58;
  localparam logic [7:0] BYTE_STAR  = 8'h2A;
  localparam logic [7:0] BYTE_LC_B  = 8'h62;
  localparam logic [7:0] BYTE_AMP   = 8'h26;
  localparam logic [7:0] BYTE_LC_P  = 8'h70;
  localparam logic [7:0] BYTE_EQUAL = 8'h3D;
  localparam logic [7:0] BYTE_DIG_0 = 8'h30;
  localparam logic [7:0] BYTE_DIG_9 = 8'h39;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC1 = 2'd1;
  localparam logic [1:0] MODE_BODY = 2'd2;

  // Output run of one held byte: first result, the rest, index of the final one
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] rest_byte;
    logic [2:0] last_idx;
  } run_t;

  // Held byte and the pulse that retires it
  typedef struct packed {
    logic       commit;
    logic [7:0] data;
  } ctl_t;

endpackage

### rtl/pepf_job_if.sv
// Input channel of the filter: one job byte per transaction.
// Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps

interface pepf_job_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/pepf_print_if.sv
// Output channel of the filter: one printer byte per transaction.
// Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps

interface pepf_print_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

### rtl/pepf_state.sv
// Filter state (mode, column, raw count, escape parse) and run decode
// of the held byte. Uses pepf_pkg.
`timescale 1ns / 1ps

module pepf_state (
  input  logic          clk,
  input  logic          rst,
  input  pepf_pkg::ctl_t ctl,
  output pepf_pkg::run_t run
);

  logic [1:0]  mode,            mode_next;
  logic [15:0] column,          column_next;
  logic [15:0] raw_remaining,   raw_remaining_next;
  logic [1:0]  escape_position, escape_position_next;
  logic [7:0]  escape_second,   escape_second_next;
  logic [7:0]  escape_third,    escape_third_next;
  logic [15:0] digit_value,     digit_value_next;
  logic        digits_done,     digits_done_next;

  logic [7:0]  c;
  logic [3:0]  tab_count;
  logic [16:0] tab_sum;
  logic [19:0] digit_sum;
  logic        is_digit;
  logic        is_final;

  assign c         = ctl.data;
  assign tab_count = 4'd8 - {1'b0, column[2:0]};
  assign tab_sum   = {1'b0, column} + {13'd0, tab_count};
  assign is_digit  = (c >= pepf_pkg::BYTE_DIG_0) && (c <= pepf_pkg::BYTE_DIG_9);
  assign digit_sum = {1'b0, digit_value, 3'b000} + {3'b000, digit_value, 1'b0}
                   + {16'd0, c[3:0]};
  assign is_final  = (c >= pepf_pkg::BYTE_AT) && (c <= pepf_pkg::BYTE_UC_Z);

  // Run decode
  always_comb begin
    run.first_byte = c;
    run.rest_byte  = c;
    run.last_idx   = 3'd0;
    if (raw_remaining == 16'd0 && mode != pepf_pkg::MODE_ESC1
        && mode != pepf_pkg::MODE_BODY) begin
      if (c == pepf_pkg::BYTE_LF) begin
        run.first_byte = pepf_pkg::BYTE_CR;
        run.last_idx   = 3'd1;
      end else if (c == pepf_pkg::BYTE_TAB) begin
        run.first_byte = pepf_pkg::BYTE_SPACE;
        run.rest_byte  = pepf_pkg::BYTE_SPACE;
        run.last_idx   = ~column[2:0];
      end
    end
  end

  // State update on retirement of the held byte
  always_comb begin
    mode_next            = mode;
    column_next          = column;
    raw_remaining_next   = raw_remaining;
    escape_position_next = escape_position;
    escape_second_next   = escape_second;
    escape_third_next    = escape_third;
    digit_value_next     = digit_value;
    digits_done_next     = digits_done;

    if (raw_remaining != 16'd0) begin
      raw_remaining_next = raw_remaining - 16'd1;
    end else begin
      unique case (mode)
        pepf_pkg::MODE_ESC1: begin
          escape_second_next   = c;
          escape_position_next = 2'd1;
          if (c == pepf_pkg::BYTE_EQUAL || c == pepf_pkg::BYTE_DIG_9
              || c == pepf_pkg::BYTE_UC_Y || c == pepf_pkg::BYTE_UC_Z) begin
            mode_next = pepf_pkg::MODE_TEXT;
          end else begin
            mode_next = pepf_pkg::MODE_BODY;
          end
        end
        pepf_pkg::MODE_BODY: begin
          if (escape_position != 2'd3) begin
            escape_position_next = escape_position + 2'd1;
          end
          if (escape_position_next == 2'd2) begin
            escape_third_next = c;
          end else if (escape_position_next == 2'd3 && !digits_done) begin
            if (is_digit) begin
              digit_value_next = (digit_sum > {4'd0, pepf_pkg::SAT16})
                               ? pepf_pkg::SAT16 : digit_sum[15:0];
            end else begin
              digits_done_next = 1'b1;
            end
          end
          if (is_final) begin
            mode_next = pepf_pkg::MODE_TEXT;
            if ((c == pepf_pkg::BYTE_UC_W && escape_second_next == pepf_pkg::BYTE_STAR
                 && escape_third_next == pepf_pkg::BYTE_LC_B)
                || (c == pepf_pkg::BYTE_UC_X && escape_second_next == pepf_pkg::BYTE_AMP
                 && escape_third_next == pepf_pkg::BYTE_LC_P)) begin
              raw_remaining_next = digit_value_next;
            end
          end
        end
        default: begin
          // text mode; the unused code falls back to text as well
          mode_next = pepf_pkg::MODE_TEXT;
          unique case (c) inside
            pepf_pkg::BYTE_ESC: begin
              mode_next            = pepf_pkg::MODE_ESC1;
              escape_position_next = 2'd0;
              escape_second_next   = 8'd0;
              escape_third_next    = 8'd0;
              digit_value_next     = 16'd0;
              digits_done_next     = 1'b0;
            end
            pepf_pkg::BYTE_LF, pepf_pkg::BYTE_CR: begin
              column_next = 16'd0;
            end
            pepf_pkg::BYTE_TAB: begin
              column_next = tab_sum[16] ? pepf_pkg::SAT16 : tab_sum[15:0];
            end
            pepf_pkg::BYTE_BS: begin
              if (column != 16'd0) begin
                column_next = column - 16'd1;
              end
            end
            default: begin
              if (c >= pepf_pkg::BYTE_SPACE && c < pepf_pkg::BYTE_DEL
                  && column != pepf_pkg::SAT16) begin
                column_next = column + 16'd1;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= pepf_pkg::MODE_TEXT;
      column          <= 16'd0;
      raw_remaining   <= 16'd0;
      escape_position <= 2'd0;
      escape_second   <= 8'd0;
      escape_third    <= 8'd0;
      digit_value     <= 16'd0;
      digits_done     <= 1'b0;
    end else if (ctl.commit) begin
      mode            <= mode_next;
      column          <= column_next;
      raw_remaining   <= raw_remaining_next;
      escape_position <= escape_position_next;
      escape_second   <= escape_second_next;
      escape_third    <= escape_third_next;
      digit_value     <= digit_value_next;
      digits_done     <= digits_done_next;
    end
  end

  // A raw byte always retires by counting down exactly one
  assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && raw_remaining != 16'd0) |=> raw_remaining == $past(raw_remaining) - 16'd1)
    else $error("raw count did not step down by one");

  // The unused mode code is never entered
  assert property (@(posedge clk) disable iff (rst)
    mode <= pepf_pkg::MODE_BODY)
    else $error("mode reached the unused code");

endmodule

### rtl/pepf_emit.sv
// Input holding register, result index counter and output register.
// Sequences the results of each held byte. Uses pepf_pkg and both channel interfaces.
`timescale 1ns / 1ps

module pepf_emit (
  input  logic            clk,
  input  logic            rst,
  pepf_job_if.sink        job,
  pepf_print_if.source    printer,
  input  pepf_pkg::run_t  run,
  output pepf_pkg::ctl_t  ctl
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic [2:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       load;
  logic       last;
  logic       commit;

  assign load   = hold_valid && (!out_valid || printer.ready);
  assign last   = (idx == run.last_idx);
  assign commit = load && last;

  assign job.ready           = !hold_valid || commit;
  assign printer.valid       = out_valid;
  assign printer.out_byte    = out_byte;
  assign printer.last_of_run = out_last;

  assign ctl.commit = commit;
  assign ctl.data   = hold_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= 3'd0;
      out_valid  <= 1'b0;
    end else begin
      if (job.valid && job.ready) begin
        hold_valid <= 1'b1;
      end else if (commit) begin
        hold_valid <= 1'b0;
      end
      if (commit) begin
        idx <= 3'd0;
      end else if (load) begin
        idx <= idx + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (printer.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid && job.ready) begin
      hold_byte <= job.in_byte;
    end
    if (load) begin
      out_byte <= (idx == 3'd0) ? run.first_byte : run.rest_byte;
      out_last <= last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> idx <= run.last_idx)
    else $error("result index ran past the end of the run");

  assert property (@(posedge clk) disable iff (rst)
    (load && !last) |=> hold_valid && idx == $past(idx) + 3'd1)
    else $error("run dropped its held byte mid-way");

  assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready) |=> hold_valid && idx == 3'd0)
    else $error("accepted byte not held from its first result");

endmodule

### rtl/printer_escape_passthrough_filter_unit.sv
// Printer escape passthrough filter, top level.
// A byte goes to the holding register, then its first result to the output register
// once that is free. Throughput: one byte per cycle while the printer keeps up; LF
// gives CR then LF, a tab 1 to 8 spaces: one result a cycle from the output register.
// Reset (rst, synchronous): text mode, column, raw count and escape parse cleared.
`timescale 1ns / 1ps

module printer_escape_passthrough_filter_unit (
  input  logic         clk,
  input  logic         rst,
  pepf_job_if.sink     job,
  pepf_print_if.source printer
);

  pepf_pkg::run_t run;
  pepf_pkg::ctl_t ctl;

  pepf_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .job     (job),
    .printer (printer),
    .run     (run),
    .ctl     (ctl)
  );

  pepf_state u_state (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .run (run)
  );

endmodule
